@@ rtl/sdiv_pkg.sv @@
// Package for the signed restoring divider: widths and the work item type
// that moves down the divide pipeline. No dependencies.
package sdiv_pkg;

    // Operand width the divider works at; the ports stay at FIELD_W bits
    localparam int DATA_WIDTH = 64;
    // Width of the dividend, divisor and quotient ports
    localparam int FIELD_W    = 64;

    // One division in flight: partial remainder, dividend bits still to
    // shift in (with quotient bits filling from the bottom), divisor
    // magnitude, and the flags needed at the end
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;
        logic [DATA_WIDTH-1:0] nq;
        logic [DATA_WIDTH-1:0] den;
        logic                  negate;
        logic                  dz;
    } sdiv_work_t;

endpackage

@@ rtl/sdiv_stage.sv @@
// One bit step of the restoring divide pipeline, with its own register.
// Depends on sdiv_pkg for the work item type.
module sdiv_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               valid_in,
    input  sdiv_pkg::sdiv_work_t work_in,
    output logic               valid_out,
    output sdiv_pkg::sdiv_work_t work_out
);
    import sdiv_pkg::*;

    logic                  valid_reg;
    sdiv_work_t            work_reg;
    sdiv_work_t            work_next;
    logic [DATA_WIDTH-1:0] rem_shift;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    // Shift the next dividend bit into the remainder, trial-subtract
    always_comb
    begin
        rem_shift = {work_in.rem[DATA_WIDTH-2:0], work_in.nq[DATA_WIDTH-1]};
        diff      = {1'b0, rem_shift} - {1'b0, work_in.den};
        fits      = ~diff[DATA_WIDTH];
        work_next        = work_in;
        work_next.rem    = fits ? diff[DATA_WIDTH-1:0] : rem_shift;
        work_next.nq     = {work_in.nq[DATA_WIDTH-2:0], fits};
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload, held while the pipeline is frozen
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

@@ rtl/signed_restoring_divider_64.sv @@
// Top level of the pipelined signed restoring divider.
// Depends on sdiv_pkg and sdiv_stage.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------
//  request | in_valid  | in_stall  | dividend, divisor
//  result  | out_valid | out_stall | quotient, divide_by_zero
//
// One request enters per cycle while in_stall is low: magnitudes are taken
// into a front register, one quotient bit is made in each sdiv_stage register
// of the chain, and the sign is fixed in the output register.
// A stalled result freezes the whole pipeline, and in_stall is raised for
// exactly those cycles. Reset clears only the valid bits.
module signed_restoring_divider_64 (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [sdiv_pkg::FIELD_W-1:0] dividend,
    input  logic signed [sdiv_pkg::FIELD_W-1:0] divisor,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [sdiv_pkg::FIELD_W-1:0] quotient,
    output logic                                divide_by_zero
);
    import sdiv_pkg::*;

    logic                        advance;
    logic                        front_valid_reg;
    sdiv_work_t                  front_work_reg;
    sdiv_work_t                  front_work_next;
    logic [DATA_WIDTH-1:0]       num_raw;
    logic [DATA_WIDTH-1:0]       den_raw;
    logic                        stage_valid [0:DATA_WIDTH];
    sdiv_work_t                  stage_work  [0:DATA_WIDTH];
    sdiv_work_t                  last_work;
    logic [DATA_WIDTH-1:0]       quo_fixed;
    logic                        out_valid_reg;
    logic signed [FIELD_W-1:0]   quotient_reg;
    logic signed [FIELD_W-1:0]   quotient_next;
    logic                        divide_by_zero_reg;

    // Freeze everything while a finished result waits
    assign advance  = ~(out_valid_reg & out_stall);
    assign in_stall = ~advance;

    // Take magnitudes and note the sign of the result
    always_comb
    begin
        num_raw = dividend[DATA_WIDTH-1:0];
        den_raw = divisor[DATA_WIDTH-1:0];
        front_work_next.rem    = '0;
        front_work_next.nq     = num_raw[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - num_raw) : num_raw;
        front_work_next.den    = den_raw[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - den_raw) : den_raw;
        front_work_next.negate = num_raw[DATA_WIDTH-1] ^ den_raw[DATA_WIDTH-1];
        front_work_next.dz     = (den_raw == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            front_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_work_reg <= front_work_next;
        end
    end

    assign stage_valid[0] = front_valid_reg;
    assign stage_work[0]  = front_work_reg;

    // One quotient bit per stage, most significant first
    for (genvar k = 1; k <= DATA_WIDTH; k++)
    begin : g_stage
        sdiv_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stage_valid[k-1]),
            .work_in   (stage_work[k-1]),
            .valid_out (stage_valid[k]),
            .work_out  (stage_work[k])
        );
    end

    // Apply the sign, force zero on a zero divisor, sign-extend
    always_comb
    begin
        last_work     = stage_work[DATA_WIDTH];
        quo_fixed     = last_work.negate ? (DATA_WIDTH'(0) - last_work.nq) : last_work.nq;
        quotient_next = last_work.dz ? '0 : FIELD_W'(signed'(quo_fixed));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid[DATA_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            quotient_reg       <= quotient_next;
            divide_by_zero_reg <= last_work.dz;
        end
    end

    assign out_valid      = out_valid_reg;
    assign quotient       = quotient_reg;
    assign divide_by_zero = divide_by_zero_reg;

`ifndef ASSERT_OFF
    // A zero divisor always comes out as a zero quotient
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> quotient == '0)
        else $error("divide by zero result carries a nonzero quotient");

    // An accepted request lands in the magnitude stage
    a_front_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> front_valid_reg)
        else $error("accepted request lost at the magnitude stage");

    // The final remainder is below the divisor for every real division
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[DATA_WIDTH] && !stage_work[DATA_WIDTH].dz
        |-> stage_work[DATA_WIDTH].rem < stage_work[DATA_WIDTH].den)
        else $error("final remainder not below divisor");
`endif

endmodule

@@ tb/sv/signed_restoring_divider_64_tb.sv @@
// Testbench for signed_restoring_divider_64: drives division requests, predicts each
// quotient and divide-by-zero flag, and checks every result in order.
// Depends on sdiv_pkg and the divider RTL.
`timescale 1ns / 1ps

module signed_restoring_divider_64_tb;

    import sdiv_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam logic signed [FIELD_W-1:0] MOST_NEG = 64'sh8000_0000_0000_0000;
    localparam logic signed [FIELD_W-1:0] MOST_POS = 64'sh7fff_ffff_ffff_ffff;
    localparam int PIPE_DEPTH  = DW + 2;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [FIELD_W-1:0] quotient;
        logic                      dz;
    } div_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [FIELD_W-1:0] dividend;
    logic signed [FIELD_W-1:0] divisor;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [FIELD_W-1:0] quotient;
    logic                      divide_by_zero;

    div_result_t quotients_due[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_cycles = 0;

    signed_restoring_divider_64 DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .dividend       (dividend),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quotient       (quotient),
        .divide_by_zero (divide_by_zero)
    );

    // Generate the clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Truncating signed division at DW bits, bit by bit as the divider does it
    function automatic div_result_t predict_quotient(input logic [FIELD_W-1:0] num_in,
                                                     input logic [FIELD_W-1:0] den_in);
        logic [63:0] mask;
        logic [63:0] sbit;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        logic        negate;
        div_result_t r;
        begin
            mask   = (DW >= 64) ? '1 : ((64'd1 << DW) - 64'd1);
            sbit   = 64'd1 << (DW - 1);
            num    = num_in & mask;
            den    = den_in & mask;
            negate = 1'b0;
            if ((num & sbit) != 0)
            begin
                num    = (64'd0 - num) & mask;
                negate = ~negate;
            end
            if ((den & sbit) != 0)
            begin
                den    = (64'd0 - den) & mask;
                negate = ~negate;
            end
            if (den == 0)
            begin
                r.quotient = '0;
                r.dz       = 1'b1;
                return r;
            end
            rem = '0;
            quo = '0;
            for (int pos = DW - 1; pos >= 0; pos--)
            begin
                rem = {rem[62:0], num[pos]};
                if (rem >= den)
                begin
                    rem      = rem - den;
                    quo[pos] = 1'b1;
                end
            end
            if (negate)
                quo = (64'd0 - quo) & mask;
            if ((quo & sbit) != 0)
                quo = quo | ~mask;
            r.quotient = quo;
            r.dz       = 1'b0;
            return r;
        end
    endfunction

    // Pick an operand: zero at the given percentage, else full range, shifted down, small, or an extreme
    function automatic logic signed [FIELD_W-1:0] random_operand(input int zero_pct);
        logic signed [FIELD_W-1:0] v;
        begin
            if ($urandom_range(99) < zero_pct)
                return '0;
            case ($urandom_range(4))
                0: v = {$urandom, $urandom};
                1: v = $signed({$urandom, $urandom}) >>> $urandom_range(63);
                2:
                begin
                    v = FIELD_W'($urandom_range(1000));
                    v = v - 64'sd500;
                end
                3:
                begin
                    case ($urandom_range(3))
                        0: v = MOST_NEG;
                        1: v = MOST_POS;
                        2: v = -64'sd1;
                        default: v = 64'sd1;
                    endcase
                end
                default: v = $signed({$urandom, $urandom}) >>> $urandom_range(40, 63);
            endcase
            return v;
        end
    endfunction

    // Offer one request, idling first at random; record its result once accepted
    task automatic send_division(input logic signed [FIELD_W-1:0] num,
                                 input logic signed [FIELD_W-1:0] den);
        begin
            while ($urandom_range(99) < tx_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            dividend <= num;
            divisor  <= den;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            quotients_due.push_back(predict_quotient(num, den));
        end
    endtask

    // Signs, rounding toward zero and the wrap of the most negative value
    task automatic test_sign_and_extremes();
        begin
            send_division(0, 1);
            send_division(1, 1);
            send_division(7, 2);
            send_division(-7, 2);
            send_division(7, -2);
            send_division(-7, -2);
            send_division(3, 5);
            send_division(MOST_POS, 1);
            send_division(MOST_POS, -1);
            send_division(MOST_NEG, 1);
            send_division(MOST_NEG, -1);
            send_division(MOST_NEG, 2);
            send_division(MOST_NEG, MOST_NEG);
            send_division(MOST_POS, MOST_NEG);
            send_division(-1, MOST_NEG);
            send_division(MOST_POS, MOST_POS);
            send_division(1, MOST_POS);
            send_division(64'sd123456789, -64'sd1000);
        end
    endtask

    // Zero divisor with several dividends
    task automatic test_divide_by_zero();
        begin
            send_division(5, 0);
            send_division(0, 0);
            send_division(-1, 0);
            send_division(MOST_NEG, 0);
            send_division(MOST_POS, 0);
        end
    endtask

    // Random requests under a given idling mix
    task automatic test_random_requests(input int count, input int tx_pct, input int rx_pct);
        begin
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            repeat (count)
                send_division(random_operand(0), random_operand(6));
        end
    endtask

    // Hold the result side off long enough for the pipeline to fill and stall requests
    task automatic test_output_hold();
        begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            hold_cycles = 4 * PIPE_DEPTH;
            repeat (2 * PIPE_DEPTH)
                send_division(random_operand(0), random_operand(6));
        end
    endtask

    // Drive stall on the result side: a long hold when asked, else random
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        div_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (quotients_due.size() == 0)
            begin
                $error("unexpected result: quotient %0d, divide_by_zero %0b",
                       quotient, divide_by_zero);
                error_count++;
            end
            else
            begin
                want = quotients_due.pop_front();
                if (quotient !== want.quotient)
                begin
                    $error("quotient: expected %0d, got %0d", want.quotient, quotient);
                    error_count++;
                end
                if (divide_by_zero !== want.dz)
                begin
                    $error("divide_by_zero: expected %0b, got %0b", want.dz, divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("signed_restoring_divider_64_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        dividend  = '0;
        divisor   = '0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sign_and_extremes();
        test_divide_by_zero();
        test_random_requests(130, 24, 56);
        test_random_requests(130, 56, 24);
        test_random_requests(130, 0, 0);
        test_output_hold();

        // Drain the pipeline
        in_valid    <= 1'b0;
        rx_idle_pct = 0;
        while (quotients_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4)
            @(posedge clk);

        if (error_count == 0)
            $display("signed_restoring_divider_64_tb: clean");
        else
            $display("signed_restoring_divider_64_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sdiv_pkg.sv
rtl/sdiv_stage.sv
rtl/signed_restoring_divider_64.sv
tb/sv/signed_restoring_divider_64_tb.sv
